// ===== src/qs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_pkg: shared constants and types for the quaternion slerp core
// Fixed-point formats, CORDIC arctangent table and pipeline depths.
// ----------------------------------------------------------------------------
package qs_pkg;

  // fixed-point format of the quaternion components and blend fraction
  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;

  // iterative units, one result bit per stage
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 32;

  // stage counts of the datapath blocks
  localparam int ANG_LAT  = 2 + SQRT_STEPS + CORDIC_STEPS + 4;
  localparam int WGT_LAT  = CORDIC_STEPS + 3 + DIV_STEPS + 1;
  localparam int MIX_LAT  = 2;
  localparam int SIDE_LAT = ANG_LAT + WGT_LAT;
  localparam int PIPE_LAT = 4 + SIDE_LAT + MIX_LAT;

  // Q30 words, and Q14 quaternion components
  typedef logic signed [32:0] ang_t;
  typedef logic signed [32:0] wgt_t;
  typedef logic [30:0]        root_t;
  typedef logic [30:0]        frac_t;
  typedef logic signed [15:0] comp_t;
  typedef logic signed [16:0] ncomp_t;

  localparam ang_t INV_GAIN = 33'sd652032874;
  localparam ang_t ONE_Q30  = 33'sd1073741824;

  // atan(2^-i) in Q30
  localparam ang_t ATAN_TAB [32] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
    33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
    33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
    33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
    33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
    33'sd1024,      33'sd512,       33'sd256,       33'sd128,
    33'sd64,        33'sd32,        33'sd16,        33'sd8,
    33'sd4,         33'sd2,         33'sd1,         33'sd0
  };

endpackage
`default_nettype wire

// ===== src/quaternion_slerp_core.sv =====
`default_nettype none
// throughput: one item per cycle while the output buffer has room, set by the fully
//   pipelined square root, CORDIC and divider stages (31 + 16 + 16 + 32 stages)
// a two-entry output buffer lets the pipeline keep accepting while a result waits
// reset: asynchronous, clears valid bits, buffer count and the linear threshold thr_q
// ----------------------------------------------------------------------------
// quaternion_slerp_core: pipelined fixed-point quaternion slerp
// Dot product and shortest-path sign, arc angle unit, two weight lanes and
// four component lanes, followed by a two-entry output buffer.
// ----------------------------------------------------------------------------
module quaternion_slerp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [14:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  qs_pkg::comp_t         first_x_i,
  input  qs_pkg::comp_t         first_y_i,
  input  qs_pkg::comp_t         first_z_i,
  input  qs_pkg::comp_t         first_w_i,
  input  qs_pkg::comp_t         second_x_i,
  input  qs_pkg::comp_t         second_y_i,
  input  qs_pkg::comp_t         second_z_i,
  input  qs_pkg::comp_t         second_w_i,
  input  logic [14:0]           blend_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output qs_pkg::comp_t         out_x_o,
  output qs_pkg::comp_t         out_y_o,
  output qs_pkg::comp_t         out_z_o,
  output qs_pkg::comp_t         out_w_o
);
  import qs_pkg::*;

  typedef struct packed {
    logic [3:0][15:0] p;
    logic [3:0][16:0] q;
    logic             lin;
    frac_t            t30;
  } side_t;

  localparam logic [14:0] T_ONE     = 15'(1 << FRAC_BITS);
  localparam int          COS_SHIFT = 30 - 2 * FRAC_BITS;
  localparam int          T_SHIFT   = 30 - FRAC_BITS;
  localparam logic signed [34:0] DOT_ONE = 35'sd1 <<< (2 * FRAC_BITS);

  logic [14:0]        thr_q;
  logic               adv;
  logic               vline_q [PIPE_LAT];

  logic [3:0][15:0]   p0_q, q0_q, p1_q, q1_q, p2_q, q2_q;
  logic [14:0]        t0_q, t1_q, t2_q;
  logic signed [31:0] prod_q [4];
  logic signed [33:0] dot_q, adot;
  logic               neg;
  side_t              side_d;
  side_t              side_q [SIDE_LAT+1];
  logic [29:0]        cos_q;
  frac_t              t30_q;

  ang_t               ang_a, ang_b;
  root_t              sin_w;
  wgt_t               wl1, wl2, w1, w2;
  logic [3:0][15:0]   res;

  logic [1:0]         cnt_q;
  logic [3:0][15:0]   slot0_q, slot1_q;
  logic               push, pop;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // pipeline moves whenever the output buffer has room
  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  // valid bits along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_LAT; k++) vline_q[k] <= 1'b0;
    end else if (adv) begin
      vline_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_LAT; k++) vline_q[k] <= vline_q[k-1];
    end
  end

  // input capture, products, dot sum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q <= {first_w_i, first_z_i, first_y_i, first_x_i};
      q0_q <= {second_w_i, second_z_i, second_y_i, second_x_i};
      t0_q <= (blend_i > T_ONE) ? T_ONE : blend_i;
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= $signed(p0_q[i]) * $signed(q0_q[i]);
      end
      p1_q  <= p0_q;
      q1_q  <= q0_q;
      t1_q  <= t0_q;
      dot_q <= 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
      p2_q  <= p1_q;
      q2_q  <= q1_q;
      t2_q  <= t1_q;
    end
  end

  // shortest path sign and near-parallel test
  always_comb begin
    neg  = dot_q[33];
    adot = neg ? -dot_q : dot_q;
    side_d.p   = p2_q;
    for (int i = 0; i < 4; i++) begin
      side_d.q[i] = neg ? 17'(-17'($signed(q2_q[i]))) : 17'($signed(q2_q[i]));
    end
    side_d.lin = ((DOT_ONE - 35'(adot)) <= $signed({6'b0, thr_q, 14'b0}));
    side_d.t30 = frac_t'({t2_q, 16'b0}) ;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      cos_q     <= 30'(adot << COS_SHIFT);
      t30_q     <= frac_t'(31'(t2_q) << T_SHIFT);
      for (int k = 1; k <= SIDE_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  qs_angle u_angle (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cos_i   (cos_q),
    .frac_i  (t30_q),
    .ang_a_o (ang_a),
    .ang_b_o (ang_b),
    .sin_o   (sin_w)
  );

  // weight lanes: first from the remaining angle, second from the blend angle
  qs_weight u_weight1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (ang_b),
    .den_i (sin_w),
    .wgt_o (wl1)
  );

  qs_weight u_weight2 (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (ang_a),
    .den_i (sin_w),
    .wgt_o (wl2)
  );

  // merge: linear weights for near-parallel items
  always_comb begin
    if (side_q[SIDE_LAT].lin) begin
      w1 = ONE_Q30 - $signed({2'b00, side_q[SIDE_LAT].t30});
      w2 = $signed({2'b00, side_q[SIDE_LAT].t30});
    end else begin
      w1 = wl1;
      w2 = wl2;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_mix
    qs_mix u_mix (
      .clk_i (clk_i),
      .en_i  (adv),
      .w1_i  (w1),
      .w2_i  (w2),
      .p_i   ($signed(side_q[SIDE_LAT].p[i])),
      .q_i   ($signed(side_q[SIDE_LAT].q[i])),
      .res_o (res[i])
    );
  end

  // two-entry output buffer
  assign push = adv & vline_q[PIPE_LAT-1];
  assign pop  = (cnt_q != 2'd0) & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      unique case (cnt_q)
        2'd0: if (push) cnt_q <= 2'd1;
        2'd1: begin
          if (push && !pop) cnt_q <= 2'd2;
          else if (!push && pop) cnt_q <= 2'd0;
        end
        2'd2: if (pop) cnt_q <= 2'd1;
        default: cnt_q <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cnt_q)
      2'd0: if (push) slot0_q <= res;
      2'd1: begin
        if (push && pop) slot0_q <= res;
        else if (push) slot1_q <= res;
      end
      2'd2: if (pop) slot0_q <= slot1_q;
      default: slot0_q <= slot0_q;
    endcase
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_x_o     = slot0_q[0];
  assign out_y_o     = slot0_q[1];
  assign out_z_o     = slot0_q[2];
  assign out_w_o     = slot0_q[3];

endmodule
`default_nettype wire

// ===== src/qs_angle.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_angle: arc angle and split angles
// Squares the cosine, takes the sine by a pipelined square root, finds the
// angle by CORDIC vectoring and splits it by the blend fraction.
// ----------------------------------------------------------------------------
module qs_angle (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [29:0]   cos_i,
  input  qs_pkg::frac_t frac_i,
  output qs_pkg::ang_t  ang_a_o,
  output qs_pkg::ang_t  ang_b_o,
  output qs_pkg::root_t sin_o
);
  import qs_pkg::*;

  logic [59:0] sq_q;
  logic [29:0] c1_q, c2_q;
  frac_t       t1_q, t2_q;
  logic [60:0] rad_q;

  // square root stage arrays
  logic [61:0] srad  [SQRT_STEPS+1];
  logic [31:0] srem  [SQRT_STEPS+1];
  root_t       sroot [SQRT_STEPS+1];
  logic [29:0] scos  [SQRT_STEPS+1];
  frac_t       sfrac [SQRT_STEPS+1];

  // vectoring arrays
  ang_t  vx [CORDIC_STEPS+1];
  ang_t  vy [CORDIC_STEPS+1];
  ang_t  vz [CORDIC_STEPS+1];
  root_t vs [CORDIC_STEPS+1];
  frac_t vt [CORDIC_STEPS+1];

  logic signed [65:0] cp_q, mt_q;
  ang_t  zc_q, om_q, om2_q, a_q, b_q, a_d;
  root_t sc_q, so_q, sm_q, sab_q;
  frac_t tc_q, to_q;

  // square and radicand
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= 60'(cos_i) * 60'(cos_i);
      c1_q  <= cos_i;
      t1_q  <= frac_i;
      rad_q <= (61'd1 << 60) - {1'b0, sq_q};
      c2_q  <= c1_q;
      t2_q  <= t1_q;
    end
  end

  assign srad[0]  = {1'b0, rad_q};
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign scos[0]  = c2_q;
  assign sfrac[0] = t2_q;

  // one root bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - j;
    logic [33:0] remx, trial;
    always_comb begin
      remx  = {srem[j], srad[j][2*K+1:2*K]};
      trial = {1'b0, sroot[j], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (remx >= trial) begin
          srem[j+1]  <= 32'(remx - trial);
          sroot[j+1] <= {sroot[j][29:0], 1'b1};
        end else begin
          srem[j+1]  <= remx[31:0];
          sroot[j+1] <= {sroot[j][29:0], 1'b0};
        end
        srad[j+1]  <= srad[j];
        scos[j+1]  <= scos[j];
        sfrac[j+1] <= sfrac[j];
      end
    end
  end

  // vectoring start point, sine never below one lsb
  assign vx[0] = $signed({3'b000, scos[SQRT_STEPS]});
  assign vy[0] = (sroot[SQRT_STEPS] == '0) ? 33'sd1
                                           : $signed({2'b00, sroot[SQRT_STEPS]});
  assign vz[0] = '0;
  assign vs[0] = (sroot[SQRT_STEPS] == '0) ? root_t'(1) : sroot[SQRT_STEPS];
  assign vt[0] = sfrac[SQRT_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    ang_t dx, dy;
    always_comb begin
      dx = vy[i] >>> i;
      dy = vx[i] >>> i;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!vy[i][32]) begin
          vx[i+1] <= vx[i] + dx;
          vy[i+1] <= vy[i] - dy;
          vz[i+1] <= vz[i] + ATAN_TAB[i];
        end else begin
          vx[i+1] <= vx[i] - dx;
          vy[i+1] <= vy[i] + dy;
          vz[i+1] <= vz[i] - ATAN_TAB[i];
        end
        vs[i+1] <= vs[i];
        vt[i+1] <= vt[i];
      end
    end
  end

  // residual correction, angle split
  assign a_d = 33'(mt_q >>> 30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cp_q  <= vy[CORDIC_STEPS] * INV_GAIN;
      zc_q  <= vz[CORDIC_STEPS];
      sc_q  <= vs[CORDIC_STEPS];
      tc_q  <= vt[CORDIC_STEPS];
      om_q  <= 33'(66'(zc_q) + (cp_q >>> 30));
      so_q  <= sc_q;
      to_q  <= tc_q;
      mt_q  <= 66'(om_q) * 66'($signed({2'b00, to_q}));
      om2_q <= om_q;
      sm_q  <= so_q;
      a_q   <= a_d;
      b_q   <= om2_q - a_d;
      sab_q <= sm_q;
    end
  end

  assign ang_a_o = a_q;
  assign ang_b_o = b_q;
  assign sin_o   = sab_q;

endmodule
`default_nettype wire

// ===== src/qs_weight.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_weight: one slerp weight lane
// Sine of the lane angle by CORDIC rotation, then a pipelined restoring
// division by the sine of the full arc.
// ----------------------------------------------------------------------------
module qs_weight (
  input  logic          clk_i,
  input  logic          en_i,
  input  qs_pkg::ang_t  ang_i,
  input  qs_pkg::root_t den_i,
  output qs_pkg::wgt_t  wgt_o
);
  import qs_pkg::*;

  ang_t  rx [CORDIC_STEPS+1];
  ang_t  ry [CORDIC_STEPS+1];
  ang_t  rz [CORDIC_STEPS+1];
  root_t rd [CORDIC_STEPS+1];

  logic signed [65:0] pp_q;
  ang_t               py_q;
  logic signed [33:0] sn_q;
  root_t              dp_q, ds_q;
  logic [33:0]        mag;

  // divider stage arrays
  logic [30:0] drem [DIV_STEPS+1];
  logic [31:0] dq   [DIV_STEPS+1];
  logic [1:0]  dlo  [DIV_STEPS+1];
  logic        dneg [DIV_STEPS+1];
  root_t       dden [DIV_STEPS+1];
  wgt_t        wgt_q;

  assign rx[0] = INV_GAIN;
  assign ry[0] = '0;
  assign rz[0] = ang_i;
  assign rd[0] = den_i;

  // rotation toward the lane angle
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    ang_t dx, dy;
    always_comb begin
      dx = ry[i] >>> i;
      dy = rx[i] >>> i;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!rz[i][32]) begin
          rx[i+1] <= rx[i] - dx;
          ry[i+1] <= ry[i] + dy;
          rz[i+1] <= rz[i] - ATAN_TAB[i];
        end else begin
          rx[i+1] <= rx[i] + dx;
          ry[i+1] <= ry[i] - dy;
          rz[i+1] <= rz[i] + ATAN_TAB[i];
        end
        rd[i+1] <= rd[i];
      end
    end
  end

  // magnitude of the corrected sine
  assign mag = sn_q[33] ? 34'(-sn_q) : 34'(sn_q);

  // residual correction and divider setup
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q    <= rx[CORDIC_STEPS] * rz[CORDIC_STEPS];
      py_q    <= ry[CORDIC_STEPS];
      dp_q    <= rd[CORDIC_STEPS];
      sn_q    <= 34'(66'(py_q) + (pp_q >>> 30));
      ds_q    <= dp_q;
      drem[0] <= 31'(mag >> 2);
      dlo[0]  <= mag[1:0];
      dq[0]   <= '0;
      dneg[0] <= sn_q[33];
      dden[0] <= ds_q;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic        nb;
    logic [31:0] remx, dv;
    always_comb begin
      if (j == 0) begin
        nb = dlo[j][1];
      end else if (j == 1) begin
        nb = dlo[j][0];
      end else begin
        nb = 1'b0;
      end
      remx = {drem[j], nb};
      dv   = {1'b0, dden[j]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (remx >= dv) begin
          drem[j+1] <= 31'(remx - dv);
          dq[j+1]   <= {dq[j][30:0], 1'b1};
        end else begin
          drem[j+1] <= remx[30:0];
          dq[j+1]   <= {dq[j][30:0], 1'b0};
        end
        dlo[j+1]  <= dlo[j];
        dneg[j+1] <= dneg[j];
        dden[j+1] <= dden[j];
      end
    end
  end

  // sign of the quotient, truncated toward zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wgt_q <= dneg[DIV_STEPS] ? -$signed({1'b0, dq[DIV_STEPS]})
                               : $signed({1'b0, dq[DIV_STEPS]});
    end
  end

  assign wgt_o = wgt_q;

endmodule
`default_nettype wire

// ===== src/qs_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qs_mix: one output component lane
// Weighted sum of the two input components, rounded and saturated.
// ----------------------------------------------------------------------------
module qs_mix (
  input  logic           clk_i,
  input  logic           en_i,
  input  qs_pkg::wgt_t   w1_i,
  input  qs_pkg::wgt_t   w2_i,
  input  qs_pkg::comp_t  p_i,
  input  qs_pkg::ncomp_t q_i,
  output qs_pkg::comp_t  res_o
);
  import qs_pkg::*;

  logic signed [48:0] m1_q;
  logic signed [49:0] m2_q;
  logic signed [50:0] acc, sh;
  comp_t              res_q;

  // round half up, floor shift
  always_comb begin
    acc = 51'(m1_q) + 51'(m2_q) + 51'sd536870912;
    sh  = acc >>> 30;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= 49'(w1_i) * 49'(p_i);
      m2_q <= 50'(w2_i) * 50'(q_i);
      if (sh > 51'sd32767) begin
        res_q <= 16'sh7fff;
      end else if (sh < -51'sd32768) begin
        res_q <= 16'sh8000;
      end else begin
        res_q <= sh[15:0];
      end
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire
